// ===== hw/rtl/polynomial_store_horner_eval_assert.svh =====
// Assertion macros shared by the polynomial store RTL.
`ifndef POLYNOMIAL_STORE_HORNER_EVAL_ASSERT_SVH
`define POLYNOMIAL_STORE_HORNER_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PSHE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pshe: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PSHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pshe: next-cycle check failed");

`endif

// ===== hw/rtl/pshe_pkg.sv =====
// Package with constants, codes and shared types of the polynomial store.
package pshe_pkg;

   localparam int MAX_TERMS = 64;
   localparam int IDX_W     = $clog2(MAX_TERMS);
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SHIFT_W   = PROD_W - FRAC_W;
   localparam int SUM_W     = SHIFT_W + 1;
   localparam int OP_W      = 2;

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_EVAL  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [IDX_W-1:0]          coef_index;
      logic signed [DATA_W-1:0]  coef_value;
      logic signed [DATA_W-1:0]  eval_point;
   } req_type;

   typedef struct packed {
      logic                      valid;
      logic signed [DATA_W-1:0]  result_value;
      logic [IDX_W-1:0]          degree;
      logic [CNT_W-1:0]          terms_used;
   } done_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
   } horner_ctl_type;

endpackage

// ===== hw/rtl/pshe_channels.sv =====
// Request and response channel interfaces of the polynomial store.
interface pshe_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [pshe_pkg::OP_W-1:0]                 op;
   logic [pshe_pkg::IDX_W-1:0]                coef_index;
   logic signed [pshe_pkg::DATA_W-1:0]        coef_value;
   logic signed [pshe_pkg::DATA_W-1:0]        eval_point;

   modport source (output valid, op, coef_index, coef_value, eval_point, input ready);
   modport sink   (input valid, op, coef_index, coef_value, eval_point, output ready);
endinterface

interface pshe_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [pshe_pkg::DATA_W-1:0]        result_value;
   logic [pshe_pkg::IDX_W-1:0]                degree;
   logic [pshe_pkg::CNT_W-1:0]                terms_used;

   modport source (output valid, result_value, degree, terms_used, input ready);
   modport sink   (input valid, result_value, degree, terms_used, output ready);
endinterface

// ===== hw/rtl/polynomial_store_horner_eval.sv =====
// Polynomial coefficient store of up to 64 signed Q16.16 terms with Horner evaluation. One
// request is worked on at a time and req_if.ready is low meanwhile; a finished response waits
// in an output register, so the next request is taken while it is still pending. A write
// zero-fills the skipped slots when it extends the term count (up to 64), and a write of zero
// to the top nonzero slot searches the lower slots one by one for the new degree. A read goes
// through ST_RD_ISSUE and ST_RD_TAKE, and a clear goes straight to ST_DONE. A nonempty evaluation
// runs ST_EV_LOAD and ST_EV_INIT, then ST_EV_MUL and ST_EV_ADD per lower coefficient: the single
// coefficient read port is shared, and the multiply-accumulate unit multiplies in ST_EV_MUL and
// shifts, adds and saturates in ST_EV_ADD. Each request waits in ST_DONE for the output register.
`include "polynomial_store_horner_eval_assert.svh"

module polynomial_store_horner_eval (
   input  logic       clock,
   input  logic       reset,
   pshe_req_if.sink   req_if,
   pshe_rsp_if.source rsp_if
);

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [pshe_pkg::DATA_W-1:0]  rsp_value_ff;
   logic [pshe_pkg::IDX_W-1:0]          rsp_degree_ff;
   logic [pshe_pkg::CNT_W-1:0]          rsp_terms_ff;
   logic                                rsp_free;
   logic                                ctrl_ready;
   logic                                start;
   pshe_pkg::req_type                   req;
   pshe_pkg::done_type                  done;

   assign start          = req_if.valid && ctrl_ready;
   assign req.op         = pshe_pkg::op_type'(req_if.op);
   assign req.coef_index = req_if.coef_index;
   assign req.coef_value = req_if.coef_value;
   assign req.eval_point = req_if.eval_point;

   // The output register is free when empty or when its content transfers in this cycle.
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   pshe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req),
      .rsp_free (rsp_free),
      .ready    (ctrl_ready),
      .done     (done)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done.valid && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid && rsp_free) begin
         rsp_value_ff  <= done.result_value;
         rsp_degree_ff <= done.degree;
         rsp_terms_ff  <= done.terms_used;
      end
   end

   assign req_if.ready        = ctrl_ready;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_value = rsp_value_ff;
   assign rsp_if.degree       = rsp_degree_ff;
   assign rsp_if.terms_used   = rsp_terms_ff;

   `PSHE_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_if.valid && req_if.ready, !req_if.ready)
   `PSHE_ASSERT_NEXT(a_done_loads_output, clock, reset, done.valid && rsp_free, rsp_valid_ff)

endmodule

// ===== hw/rtl/pshe_horner_unit.sv =====
// Shared multiply, shift, add and saturate unit for one Horner step.
module pshe_horner_unit (
   input  logic                                clock,
   input  pshe_pkg::horner_ctl_type            ctl,
   input  logic signed [pshe_pkg::DATA_W-1:0]  x,
   input  logic signed [pshe_pkg::DATA_W-1:0]  coef,
   output logic signed [pshe_pkg::DATA_W-1:0]  sum_sat
);

   logic signed [pshe_pkg::DATA_W-1:0]  y_ff;
   logic signed [pshe_pkg::DATA_W-1:0]  y_in;
   logic signed [pshe_pkg::PROD_W-1:0]  prod_ff;
   logic signed [pshe_pkg::PROD_W-1:0]  prod_in;
   logic signed [pshe_pkg::SHIFT_W-1:0] shifted;
   logic signed [pshe_pkg::SUM_W-1:0]   sum;

   assign prod_in = y_ff * x;

   // Taking the upper bits of the product is an arithmetic shift that rounds towards minus infinity.
   assign shifted = prod_ff[pshe_pkg::PROD_W-1:pshe_pkg::FRAC_W];
   assign sum     = pshe_pkg::SUM_W'(shifted) + pshe_pkg::SUM_W'(coef);

   always_comb begin
      if (sum > pshe_pkg::SUM_W'(pshe_pkg::SAT_MAX)) begin
         sum_sat = pshe_pkg::SAT_MAX;
      end else if (sum < pshe_pkg::SUM_W'(pshe_pkg::SAT_MIN)) begin
         sum_sat = pshe_pkg::SAT_MIN;
      end else begin
         sum_sat = sum[pshe_pkg::DATA_W-1:0];
      end
   end

   always_comb begin
      y_in = y_ff;
      if (ctl.load) begin
         y_in = coef;
      end else if (ctl.acc) begin
         y_in = sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      y_ff <= y_in;
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== hw/rtl/pshe_ctrl.sv =====
// Sequencer with coefficient memory, term count and degree tracking.
`include "polynomial_store_horner_eval_assert.svh"

module pshe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  pshe_pkg::req_type    req,
   input  logic                 rsp_free,
   output logic                 ready,
   output pshe_pkg::done_type   done
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_FILL     = 12'b0000_0000_0010,
      ST_COMMIT   = 12'b0000_0000_0100,
      ST_SCAN_RD  = 12'b0000_0000_1000,
      ST_SCAN_CHK = 12'b0000_0001_0000,
      ST_RD_ISSUE = 12'b0000_0010_0000,
      ST_RD_TAKE  = 12'b0000_0100_0000,
      ST_EV_LOAD  = 12'b0000_1000_0000,
      ST_EV_INIT  = 12'b0001_0000_0000,
      ST_EV_MUL   = 12'b0010_0000_0000,
      ST_EV_ADD   = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type                           state_ff, state_in;
   logic [pshe_pkg::IDX_W-1:0]          idx_ff;
   logic signed [pshe_pkg::DATA_W-1:0]  val_ff;
   logic signed [pshe_pkg::DATA_W-1:0]  x_ff;
   logic [pshe_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [pshe_pkg::IDX_W-1:0]          deg_ff, deg_in;
   logic [pshe_pkg::IDX_W-1:0]          ptr_ff, ptr_in;
   logic signed [pshe_pkg::DATA_W-1:0]  res_ff, res_in;
   logic signed [pshe_pkg::DATA_W-1:0]  rd_data_ff;
   logic signed [pshe_pkg::DATA_W-1:0]  mem [pshe_pkg::MAX_TERMS];

   logic [pshe_pkg::IDX_W-1:0]          rd_addr;
   logic [pshe_pkg::IDX_W-1:0]          wr_addr;
   logic signed [pshe_pkg::DATA_W-1:0]  wr_data;
   logic                                wr_en;
   logic [pshe_pkg::CNT_W-1:0]          idx_wide;
   logic [pshe_pkg::CNT_W-1:0]          deg_wide;
   logic [pshe_pkg::CNT_W-1:0]          req_idx_wide;
   logic [pshe_pkg::CNT_W-1:0]          count_less1;
   logic signed [pshe_pkg::DATA_W-1:0]  sum_sat;
   pshe_pkg::horner_ctl_type            hctl;

   assign idx_wide     = {1'b0, idx_ff};
   assign deg_wide     = {1'b0, deg_ff};
   assign req_idx_wide = {1'b0, req.coef_index};
   assign count_less1  = count_ff - pshe_pkg::CNT_W'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      deg_in   = deg_ff;
      ptr_in   = ptr_ff;
      res_in   = res_ff;
      rd_addr  = idx_ff;
      wr_addr  = idx_ff;
      wr_data  = val_ff;
      wr_en    = 1'b0;
      hctl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req.op)
                  pshe_pkg::OP_WRITE: begin
                     if (count_ff < req_idx_wide) begin
                        ptr_in   = count_ff[pshe_pkg::IDX_W-1:0];
                        state_in = ST_FILL;
                     end else begin
                        state_in = ST_COMMIT;
                     end
                  end
                  pshe_pkg::OP_READ: begin
                     state_in = ST_RD_ISSUE;
                  end
                  pshe_pkg::OP_EVAL: begin
                     if (count_ff == '0) begin
                        res_in   = '0;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_EV_LOAD;
                     end
                  end
                  pshe_pkg::OP_CLEAR: begin
                     count_in = '0;
                     deg_in   = '0;
                     res_in   = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            // Slots between the old count and the target index are zero-filled one per cycle.
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = '0;
            ptr_in  = ptr_ff + pshe_pkg::IDX_W'(1);
            if (ptr_in == idx_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            wr_en  = 1'b1;
            res_in = val_ff;
            if (count_ff <= idx_wide) begin
               count_in = idx_wide + pshe_pkg::CNT_W'(1);
            end
            if (val_ff != '0) begin
               if (idx_ff >= deg_ff) begin
                  deg_in = idx_ff;
               end
               state_in = ST_DONE;
            end else if ((idx_ff == deg_ff) && (idx_ff != '0)) begin
               // The top nonzero slot was cleared, so search downwards for the new degree.
               ptr_in   = idx_ff - pshe_pkg::IDX_W'(1);
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            rd_addr  = ptr_ff;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (rd_data_ff != '0) begin
               deg_in   = ptr_ff;
               state_in = ST_DONE;
            end else if (ptr_ff == '0) begin
               deg_in   = '0;
               state_in = ST_DONE;
            end else begin
               ptr_in   = ptr_ff - pshe_pkg::IDX_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_RD_ISSUE: begin
            rd_addr  = idx_ff;
            state_in = ST_RD_TAKE;
         end
         ST_RD_TAKE: begin
            res_in   = (idx_wide < count_ff) ? rd_data_ff : '0;
            state_in = ST_DONE;
         end
         ST_EV_LOAD: begin
            rd_addr  = count_less1[pshe_pkg::IDX_W-1:0];
            ptr_in   = count_less1[pshe_pkg::IDX_W-1:0];
            state_in = ST_EV_INIT;
         end
         ST_EV_INIT: begin
            hctl.load = 1'b1;
            if (ptr_ff == '0) begin
               res_in   = rd_data_ff;
               state_in = ST_DONE;
            end else begin
               state_in = ST_EV_MUL;
            end
         end
         ST_EV_MUL: begin
            // The product is formed while the next lower coefficient is fetched.
            hctl.mul = 1'b1;
            rd_addr  = ptr_ff - pshe_pkg::IDX_W'(1);
            ptr_in   = ptr_ff - pshe_pkg::IDX_W'(1);
            state_in = ST_EV_ADD;
         end
         ST_EV_ADD: begin
            hctl.acc = 1'b1;
            if (ptr_ff == '0) begin
               res_in   = sum_sat;
               state_in = ST_DONE;
            end else begin
               state_in = ST_EV_MUL;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         deg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         deg_ff   <= deg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff <= req.coef_index;
         val_ff <= req.coef_value;
         x_ff   <= req.eval_point;
      end
      ptr_ff <= ptr_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   pshe_horner_unit u_horner (
      .clock   (clock),
      .ctl     (hctl),
      .x       (x_ff),
      .coef    (rd_data_ff),
      .sum_sat (sum_sat)
   );

   assign ready              = (state_ff == ST_IDLE);
   assign done.valid         = (state_ff == ST_DONE);
   assign done.result_value  = res_ff;
   assign done.degree        = deg_ff;
   assign done.terms_used    = count_ff;

   `PSHE_ASSERT_NEXT(a_clear_empties, clock, reset, start && (req.op == pshe_pkg::OP_CLEAR), (count_ff == '0) && (deg_ff == '0))
   `PSHE_ASSERT_IMPL(a_deg_below_count, clock, reset, count_ff != '0, deg_wide < count_ff)
   `PSHE_ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == ST_DONE) && !rsp_free, state_ff == ST_DONE)
   `PSHE_ASSERT_NEXT(a_write_not_idle, clock, reset, start && (req.op == pshe_pkg::OP_WRITE), (state_ff == ST_FILL) || (state_ff == ST_COMMIT))

endmodule

// ===== verif/polynomial_store_horner_eval_checker.sv =====
// Response checker for the polynomial store: predicts every response and compares each transfer.
module polynomial_store_horner_eval_checker
   import pshe_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pshe_req_if  req_mon,
   pshe_rsp_if  rsp_mon,
   output int   failures,
   output int   outstanding
);

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         degree;
      logic [CNT_W-1:0]         terms;
   } poly_result_type;

   logic signed [DATA_W-1:0] coef_mem [MAX_TERMS];
   logic [CNT_W-1:0]         live_terms;
   poly_result_type          pending_results [$];

   function automatic logic signed [DATA_W-1:0] horner_at(input logic signed [DATA_W-1:0] x);
      longint acc;
      int     k;
      if (live_terms == 0) return '0;
      acc = longint'(coef_mem[live_terms - 1'b1]);
      // Every step floors the Q16.16 product and clamps the sum to 32 bits.
      for (k = int'(live_terms) - 2; k >= 0; k--) begin
         acc = ((acc * longint'(x)) >>> FRAC_W) + longint'(coef_mem[k]);
         if (acc > longint'(SAT_MAX)) acc = longint'(SAT_MAX);
         else if (acc < longint'(SAT_MIN)) acc = longint'(SAT_MIN);
      end
      return DATA_W'(acc);
   endfunction

   function automatic poly_result_type apply_request(input op_type op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic signed [DATA_W-1:0] value,
                                                     input logic signed [DATA_W-1:0] point);
      poly_result_type res;
      int              k;
      res = '0;
      case (op)
         OP_WRITE: begin
            // A write past the last term in use fills the gap with zero coefficients.
            while (live_terms <= CNT_W'(idx)) begin
               coef_mem[live_terms] = '0;
               live_terms = live_terms + 1'b1;
            end
            coef_mem[idx] = value;
            res.value = value;
         end
         OP_READ:  if (CNT_W'(idx) < live_terms) res.value = coef_mem[idx];
         OP_EVAL:  res.value = horner_at(point);
         OP_CLEAR: live_terms = '0;
      endcase
      for (k = int'(live_terms) - 1; k > 0; k--) begin
         if (coef_mem[k] != '0) begin
            res.degree = IDX_W'(k);
            break;
         end
      end
      res.terms = live_terms;
      return res;
   endfunction

   always @(posedge clock) begin
      poly_result_type want;
      int              errs;
      errs = 0;
      if (reset) begin
         live_terms = '0;
         pending_results.delete();
         failures    <= 0;
         outstanding <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(apply_request(op_type'(req_mon.op), req_mon.coef_index,
                                                    req_mon.coef_value, req_mon.eval_point));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               errs++;
               $error("response transfer with nothing expected: result_value %0d",
                      rsp_mon.result_value);
            end else begin
               want = pending_results.pop_front();
               if (rsp_mon.result_value !== want.value) begin
                  errs++;
                  $error("result_value: expected %0d, got %0d", want.value,
                         rsp_mon.result_value);
               end
               if (rsp_mon.degree !== want.degree) begin
                  errs++;
                  $error("degree: expected %0d, got %0d", want.degree, rsp_mon.degree);
               end
               if (rsp_mon.terms_used !== want.terms) begin
                  errs++;
                  $error("terms_used: expected %0d, got %0d", want.terms,
                         rsp_mon.terms_used);
               end
            end
         end
         failures    <= failures + errs;
         outstanding <= pending_results.size();
      end
   end

endmodule

// ===== verif/polynomial_store_horner_eval_test.sv =====
// Testbench top for the polynomial store: clock, reset, request and response pacing, verdict.
module polynomial_store_horner_eval_test;
   import pshe_pkg::*;

   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   int   issued;
   bit   sender_calm;

   pshe_req_if req_if ();
   pshe_rsp_if rsp_if ();

   polynomial_store_horner_eval dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   polynomial_store_horner_eval_checker poly_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_coef();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2: begin
            case ($urandom_range(0, 3))
               0: return SAT_MAX;
               1: return SAT_MIN;
               2: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         3, 4: return $urandom;
         default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   // Mostly points near the unit circle, which keep long polynomials out of saturation.
   function automatic logic signed [DATA_W-1:0] rand_point();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
         4: begin
            if ($urandom_range(0, 1) == 1)
               return Q_ONE + $signed($urandom_range(0, 511)) - 32'sd256;
            return -Q_ONE + $signed($urandom_range(0, 511)) - 32'sd256;
         end
         5: return '0;
         6: return ($urandom_range(0, 1) == 1) ? SAT_MAX : SAT_MIN;
         default: return $urandom;
      endcase
   endfunction

   task automatic issue(input op_type op, input int idx,
                        input logic signed [DATA_W-1:0] value,
                        input logic signed [DATA_W-1:0] point);
      int gap;
      if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
      gap = (!sender_calm && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.op         <= op;
      req_if.coef_index <= IDX_W'(idx);
      req_if.coef_value <= value;
      req_if.eval_point <= point;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      issued++;
   endtask

   initial begin : response_pacing
      int stall;
      bit calm;
      stall = 0;
      calm  = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 299) == 0) calm = !calm;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30) stall = pick_gap();
         end
      end
   end

   initial begin : stimulus
      int r;
      int n;
      int k;
      int top_idx;
      issued      = 0;
      sender_calm = 1'b0;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.op         <= OP_WRITE;
      req_if.coef_index <= '0;
      req_if.coef_value <= '0;
      req_if.eval_point <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty store, the full index range, saturation both ways and floor rounding.
      issue(OP_EVAL,  0,  '0, Q_ONE);
      issue(OP_READ,  0,  '0, '0);
      issue(OP_READ,  63, '0, '0);
      issue(OP_WRITE, 0,  SAT_MAX, '0);
      issue(OP_EVAL,  0,  '0, SAT_MIN);
      issue(OP_WRITE, 63, SAT_MIN, '0);
      issue(OP_READ,  63, '0, '0);
      issue(OP_READ,  30, '0, '0);
      issue(OP_EVAL,  0,  '0, Q_ONE);
      issue(OP_EVAL,  0,  '0, SAT_MAX);
      issue(OP_WRITE, 63, '0, '0);
      issue(OP_READ,  63, '0, '0);
      issue(OP_CLEAR, 0,  '0, '0);
      issue(OP_EVAL,  0,  '0, Q_ONE);
      issue(OP_READ,  0,  '0, '0);
      issue(OP_WRITE, 2,  32'sh0001_8000, '0);
      issue(OP_WRITE, 0,  -Q_ONE, '0);
      issue(OP_EVAL,  0,  '0, 32'shFFFE_0000);
      issue(OP_EVAL,  0,  '0, 32'shFFFF_FFFF);
      issue(OP_WRITE, 5,  SAT_MAX, '0);
      issue(OP_EVAL,  0,  '0, SAT_MAX);
      issue(OP_WRITE, 5,  SAT_MIN, '0);
      issue(OP_EVAL,  0,  '0, SAT_MAX);
      issue(OP_CLEAR, 0,  '0, '0);

      while (issued < 940) begin
         if ($urandom_range(0, 99) < 85) begin
            // Build a polynomial, then evaluate it and read parts of it back.
            r = $urandom_range(0, 99);
            n = (r < 70) ? $urandom_range(1, 6) : (r < 90) ? $urandom_range(7, 20)
                                                           : $urandom_range(21, 64);
            top_idx = n - 1;
            if ($urandom_range(0, 2) == 0) issue(OP_CLEAR, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 99) < 60) begin
               for (k = 0; k < n; k++) issue(OP_WRITE, k, rand_coef(), $urandom);
            end else begin
               issue(OP_WRITE, top_idx, rand_coef(), $urandom);
               repeat ($urandom_range(0, 3))
                  issue(OP_WRITE, $urandom_range(0, top_idx), rand_coef(), $urandom);
            end
            if ($urandom_range(0, 4) == 0) issue(OP_WRITE, top_idx, '0, $urandom);
            repeat ($urandom_range(1, 4)) issue(OP_EVAL, $urandom, $urandom, rand_point());
            repeat ($urandom_range(1, 3))
               issue(OP_READ, $urandom_range(0, (top_idx + 3 > 63) ? 63 : top_idx + 3),
                     $urandom, $urandom);
         end else begin
            repeat ($urandom_range(1, 5))
               issue(op_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (300) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
